@@ rtl/core/throttle_duty_slew_limiter_top_macros.svh @@
// assertion macros shared by the throttle duty slew limiter rtl
`ifndef THROTTLE_DUTY_SLEW_LIMITER_TOP_MACROS_SVH
`define THROTTLE_DUTY_SLEW_LIMITER_TOP_MACROS_SVH

// same-cycle implication, off while reset is low
`define TDSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define TDSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tdsl_pkg.sv @@
// types and constants of the throttle duty slew limiter
package tdsl_pkg;

    localparam int DUTY_W = 16;
    localparam int IDX_W  = 3;

    localparam logic [DUTY_W-1:0] DEAD_ZONE = 16'd2000;
    localparam logic [DUTY_W-1:0] POT_TOP   = 16'd64000;
    localparam logic [DUTY_W-1:0] POT_SPAN  = POT_TOP - DEAD_ZONE;

    // divide by 62000 = (x >> 4) / 3875, the latter by a rounded-up reciprocal
    localparam int PRE_SHIFT   = 4;
    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_W     = 29;
    localparam logic [RECIP_W-1:0] RECIP = 29'd283744937;
    localparam int PROD_W      = 2 * DUTY_W;
    localparam int X_W         = PROD_W - PRE_SHIFT;
    localparam int QP_W        = X_W + RECIP_W;

    localparam logic [DUTY_W-1:0] RST_IDLE_DUTY    = 16'd1000;
    localparam logic [DUTY_W-1:0] RST_DUTY_CEIL    = 16'd60000;
    localparam logic [DUTY_W-1:0] RST_SLEW_UP      = 16'd25;
    localparam logic [DUTY_W-1:0] RST_SLEW_DOWN    = 16'd10;
    localparam logic [DUTY_W-1:0] RST_SETTLE_TICKS = 16'd2000;

    typedef enum logic [IDX_W-1:0] {
        REG_IDLE_DUTY    = 3'd0,
        REG_DUTY_CEIL    = 3'd1,
        REG_SLEW_UP      = 3'd2,
        REG_SLEW_DOWN    = 3'd3,
        REG_SETTLE_TICKS = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [DUTY_W-1:0] idle_duty;
        logic [DUTY_W-1:0] duty_ceil;
        logic [DUTY_W-1:0] slew_up;
        logic [DUTY_W-1:0] slew_down;
        logic [DUTY_W-1:0] settle_ticks;
    } t_cfg;

    typedef struct packed {
        logic              command;
        logic [DUTY_W-1:0] pot_raw;
        logic              zc_synced;
        logic [DUTY_W-1:0] seed_duty;
    } t_in_item;

    typedef struct packed {
        logic              command;
        logic              use_idle;
        logic [DUTY_W-1:0] seed_duty;
        logic [PROD_W-1:0] prod;
    } t_prod_item;

    typedef struct packed {
        logic              command;
        logic              use_idle;
        logic [DUTY_W-1:0] seed_duty;
        logic [DUTY_W-1:0] quot;
    } t_map_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              settling;
    } t_out_item;

    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic out_load;
    } t_pipe_en;

    typedef struct packed {
        logic [DUTY_W-1:0] held;
        logic [DUTY_W-1:0] settle_left;
    } t_slew_stat;

endpackage

@@ rtl/core/tdsl_ifs.sv @@
// valid/ready channel interfaces of the throttle duty slew limiter
interface tdsl_in_if;
    import tdsl_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [DUTY_W-1:0] pot_raw;
    logic              zc_synced;
    logic [DUTY_W-1:0] seed_duty;
    modport source (output valid, output command, output pot_raw, output zc_synced,
                    output seed_duty, input ready);
    modport sink   (input valid, input command, input pot_raw, input zc_synced,
                    input seed_duty, output ready);
endinterface

interface tdsl_out_if;
    import tdsl_pkg::*;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;
    logic              settling;
    modport source (output valid, output duty, output settling, input ready);
    modport sink   (input valid, input duty, input settling, output ready);
endinterface

interface tdsl_cfg_if;
    import tdsl_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DUTY_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/throttle_duty_slew_limiter_top.sv @@
// top level of the throttle duty slew limiter
//
// i_in carries one beat per control tick: command (0 tick, 1 enter closed
// loop), pot_raw, zc_synced and seed_duty. o_res returns exactly one beat
// per input beat, in order: the duty to apply and the settling flag.
// i_cfg writes registers 0..4 (idle_duty, duty_ceil, slew_up, slew_down,
// settle_ticks); ready is always high, unknown indexes are dropped, and
// writes are meant for when the block is empty.
// the datapath is a four-register pipeline: input register, span product
// multiplier, reciprocal multiplier for the divide by 62000, and the slew
// stage that updates the held duty and loads the result register.
// throughput is one beat per cycle while o_res is not stalled.
// the held duty and settle count change only in the last stage, so items
// following each other in adjacent cycles see each other's updates.
// reset clears the pipeline, zeroes held duty and settle count and loads
// the register defaults. a stalled o_res holds its beat; bubbles close up
// behind it, and i_in.ready drops only once every stage is occupied.
`include "throttle_duty_slew_limiter_top_macros.svh"

module throttle_duty_slew_limiter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdsl_in_if.sink     i_in,
    tdsl_out_if.source  o_res,
    tdsl_cfg_if.sink    i_cfg
);
    import tdsl_pkg::*;

    // pipeline occupancy, one bit per stage
    logic r_v0;
    logic r_v1;
    logic r_v2;
    logic r_vo;

    // a stage may take new data when empty or when it hands its beat on
    logic w_free_o;
    logic w_free2;
    logic w_free1;
    logic w_free0;

    t_in_item   r_s0;
    t_pipe_en   w_en;
    t_cfg       w_cfg;
    t_map_item  w_s2;
    t_out_item  w_res;
    t_slew_stat w_stat;

    assign w_free_o = !r_vo || o_res.ready;
    assign w_free2  = !r_v2 || w_free_o;
    assign w_free1  = !r_v1 || w_free2;
    assign w_free0  = !r_v0 || w_free1;

    assign w_en.s1_load  = r_v0 && w_free1;
    assign w_en.s2_load  = r_v1 && w_free2;
    assign w_en.out_load = r_v2 && w_free_o;

    assign i_in.ready = w_free0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_free0) begin
                r_v0 <= i_in.valid;
            end
            if (w_free1) begin
                r_v1 <= r_v0;
            end
            if (w_free2) begin
                r_v2 <= r_v1;
            end
            if (w_free_o) begin
                r_vo <= r_v2;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (w_free0 && i_in.valid) begin
            r_s0.command   <= i_in.command;
            r_s0.pot_raw   <= i_in.pot_raw;
            r_s0.zc_synced <= i_in.zc_synced;
            r_s0.seed_duty <= i_in.seed_duty;
        end
    end

    tdsl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // throttle reading to mapped offset above idle
    tdsl_map u_map (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_cfg  (w_cfg),
        .i_item (r_s0),
        .o_item (w_s2)
    );

    // target select, slew limit, settle hold and result register
    tdsl_slew u_slew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (w_cfg),
        .i_item  (w_s2),
        .o_res   (w_res),
        .o_stat  (w_stat)
    );

    assign o_res.valid    = r_vo;
    assign o_res.duty     = w_res.duty;
    assign o_res.settling = w_res.settling;

    // an enter command arms the settle count from the register
    `TDSL_ASSERT_NEXT(a_settle_seed, i_clk, i_rst_n, w_en.out_load && w_s2.command,
        w_stat.settle_left == $past(w_cfg.settle_ticks), "settle count not seeded")
    // a tick during the settle hold leaves the duty alone
    `TDSL_ASSERT_NEXT(a_settle_hold, i_clk, i_rst_n,
        w_en.out_load && !w_s2.command && (w_stat.settle_left != '0),
        w_stat.held == $past(w_stat.held), "duty moved during settle hold")
    // state moves only when a beat enters the result register
    `TDSL_ASSERT_NEXT(a_state_quiet, i_clk, i_rst_n, !w_en.out_load,
        $stable(w_stat.held) && $stable(w_stat.settle_left), "state changed without a beat")
    // the shown duty is the held duty
    `TDSL_ASSERT_NOW(a_duty_held, i_clk, i_rst_n, o_res.valid,
        o_res.duty == w_stat.held, "result duty differs from held duty")

endmodule

@@ rtl/core/tdsl_cfg_regs.sv @@
// configuration register file of the throttle duty slew limiter
module tdsl_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tdsl_cfg_if.sink      i_cfg,
    output tdsl_pkg::t_cfg o_cfg
);
    import tdsl_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_duty    <= RST_IDLE_DUTY;
            r_cfg.duty_ceil    <= RST_DUTY_CEIL;
            r_cfg.slew_up      <= RST_SLEW_UP;
            r_cfg.slew_down    <= RST_SLEW_DOWN;
            r_cfg.settle_ticks <= RST_SETTLE_TICKS;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_IDLE_DUTY:    r_cfg.idle_duty    <= i_cfg.data;
                REG_DUTY_CEIL:    r_cfg.duty_ceil    <= i_cfg.data;
                REG_SLEW_UP:      r_cfg.slew_up      <= i_cfg.data;
                REG_SLEW_DOWN:    r_cfg.slew_down    <= i_cfg.data;
                REG_SETTLE_TICKS: r_cfg.settle_ticks <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/tdsl_map.sv @@
// throttle map: span product stage and reciprocal divide stage
module tdsl_map (
    input  logic                i_clk,
    input  tdsl_pkg::t_pipe_en  i_en,
    input  tdsl_pkg::t_cfg      i_cfg,
    input  tdsl_pkg::t_in_item  i_item,
    output tdsl_pkg::t_map_item o_item
);
    import tdsl_pkg::*;

    logic              w_below;
    logic [DUTY_W-1:0] w_adj;
    logic [DUTY_W-1:0] w_span;
    logic [PROD_W-1:0] w_prod;
    logic [X_W-1:0]    w_x;
    logic [QP_W-1:0]   w_qprod;
    t_prod_item        r_s1;
    t_map_item         r_s2;

    // stage 1: clamp reading, offset by dead zone, times duty span
    assign w_below = i_item.pot_raw < DEAD_ZONE;
    assign w_adj   = (i_item.pot_raw > POT_TOP) ? POT_SPAN : (i_item.pot_raw - DEAD_ZONE);
    assign w_span  = (i_cfg.duty_ceil >= i_cfg.idle_duty) ?
                     (i_cfg.duty_ceil - i_cfg.idle_duty) : '0;
    assign w_prod  = PROD_W'(w_adj) * PROD_W'(w_span);

    always_ff @(posedge i_clk) begin
        if (i_en.s1_load) begin
            r_s1.command   <= i_item.command;
            r_s1.use_idle  <= w_below || !i_item.zc_synced;
            r_s1.seed_duty <= i_item.seed_duty;
            r_s1.prod      <= w_prod;
        end
    end

    // stage 2: exact floor divide by the map span
    assign w_x     = r_s1.prod[PROD_W-1:PRE_SHIFT];
    assign w_qprod = QP_W'(w_x) * QP_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.s2_load) begin
            r_s2.command   <= r_s1.command;
            r_s2.use_idle  <= r_s1.use_idle;
            r_s2.seed_duty <= r_s1.seed_duty;
            r_s2.quot      <= w_qprod[RECIP_SHIFT +: DUTY_W];
        end
    end

    assign o_item = r_s2;

endmodule

@@ rtl/core/tdsl_slew.sv @@
// held duty, settle counter, slew limiting and result register
module tdsl_slew (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tdsl_pkg::t_pipe_en   i_en,
    input  tdsl_pkg::t_cfg       i_cfg,
    input  tdsl_pkg::t_map_item  i_item,
    output tdsl_pkg::t_out_item  o_res,
    output tdsl_pkg::t_slew_stat o_stat
);
    import tdsl_pkg::*;

    logic [DUTY_W-1:0] r_held;
    logic [DUTY_W-1:0] r_left;
    logic [DUTY_W-1:0] n_held;
    logic [DUTY_W-1:0] n_left;
    logic [DUTY_W:0]   w_mapped;
    logic [DUTY_W-1:0] w_target;
    logic [DUTY_W-1:0] w_diff_up;
    logic [DUTY_W-1:0] w_diff_dn;
    t_out_item         r_res;

    assign w_mapped  = (DUTY_W+1)'(i_cfg.idle_duty) + (DUTY_W+1)'(i_item.quot);
    assign w_target  = i_item.use_idle ? i_cfg.idle_duty :
                       (w_mapped > (DUTY_W+1)'(i_cfg.duty_ceil)) ? i_cfg.duty_ceil :
                       w_mapped[DUTY_W-1:0];
    assign w_diff_up = w_target - r_held;
    assign w_diff_dn = r_held - w_target;

    always_comb begin
        n_held = r_held;
        n_left = r_left;
        if (i_item.command) begin
            n_held = i_item.seed_duty;
            n_left = i_cfg.settle_ticks;
        end else if (r_left != '0) begin
            n_left = r_left - 1'b1;
        end else if (w_target > r_held) begin
            n_held = r_held + ((w_diff_up > i_cfg.slew_up) ? i_cfg.slew_up : w_diff_up);
        end else if (r_held > w_target) begin
            n_held = r_held - ((w_diff_dn > i_cfg.slew_down) ? i_cfg.slew_down : w_diff_dn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_left <= '0;
        end else if (i_en.out_load) begin
            r_held <= n_held;
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.out_load) begin
            r_res.duty     <= n_held;
            r_res.settling <= n_left != '0;
        end
    end

    assign o_res              = r_res;
    assign o_stat.held        = r_held;
    assign o_stat.settle_left = r_left;

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the throttle duty slew limiter: directed plan, then random phases
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tdsl_pkg::*;

    // command codes carried in the beat
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_ENTER = 1'b1;

    // quiet cycles allowed before the run is declared hung; the longest legal
    // quiet stretch is the long receiver hold plus the pipeline latency
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 60;
    localparam int PHASES        = 5;
    localparam int PHASE_BEATS   = 130;
    localparam int TAIL_CYCLES   = 12;
    localparam int REPORT_LIMIT  = 10;

    typedef enum bit {ROW_BEAT, ROW_WRITE} t_row_kind;

    // one row of the directed plan: either a register write or a beat,
    // with a hand-computed result where it is obvious
    typedef struct packed {
        t_row_kind         kind;
        t_reg_idx          reg_idx;
        logic [DUTY_W-1:0] wdata;
        logic              command;
        logic [DUTY_W-1:0] pot_raw;
        logic              zc_synced;
        logic [DUTY_W-1:0] seed_duty;
        logic              typed;
        logic [DUTY_W-1:0] want_duty;
        logic              want_settling;
    } t_plan_row;

    localparam int PLAN_ROWS = 36;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tdsl_in_if  in_ch();
    tdsl_out_if res_ch();
    tdsl_cfg_if cfg_ch();

    throttle_duty_slew_limiter_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #4 i_clk = ~i_clk;

    // shadow registers and duty state of the predictor
    t_cfg              reg_shadow;
    logic [DUTY_W-1:0] duty_now;
    logic [DUTY_W-1:0] hold_left;

    // duty beats still owed by the block, oldest first
    t_out_item duty_expect_q[$];

    int fail_count    = 0;
    int quiet_cycles  = 0;
    int send_gap_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req      = 1'b0;

    // directed plan: reset defaults first, then extremes of the map and the slew
    t_plan_row dir_plan [PLAN_ROWS] = '{
        // defaults: slew up by 25 from zero, unsynced target is idle
        '{ROW_BEAT,  REG_IDLE_DUTY,    16'd0, CMD_TICK,  16'd0,     1'b1, 16'd0, 1'b1, 16'd25, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY,    16'd0, CMD_TICK,  16'd65535, 1'b0, 16'd0, 1'b1, 16'd50, 1'b0},
        // enter with full seed, then one held tick
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_ENTER, 16'd0, 1'b0, 16'd65535, 1'b1, 16'd65535, 1'b1},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd65535, 1'b1, 16'd0, 1'b1, 16'd65535, 1'b1},
        '{ROW_WRITE, REG_SETTLE_TICKS, 16'd1, CMD_TICK,  16'd0,     1'b0, 16'd0, 1'b0, 16'd0,  1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_ENTER, 16'd0, 1'b1, 16'd30000, 1'b1, 16'd30000, 1'b1},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd65535, 1'b1, 16'd0, 1'b1, 16'd30000, 1'b0},
        // dead zone and pot top edges
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd65535, 1'b1, 16'd0, 1'b1, 16'd30025, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd1999,  1'b1, 16'd0, 1'b1, 16'd30015, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd2000,  1'b1, 16'd0, 1'b1, 16'd30005, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd64000, 1'b1, 16'd0, 1'b1, 16'd30030, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd64001, 1'b1, 16'd0, 1'b1, 16'd30055, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd12345, 1'b1, 16'd0, 1'b0, 16'd0,     1'b0},
        // unlimited slew, no settle
        '{ROW_WRITE, REG_SLEW_UP,      16'd65535, CMD_TICK, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, REG_SLEW_DOWN,    16'd65535, CMD_TICK, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, REG_SETTLE_TICKS, 16'd0,     CMD_TICK, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_ENTER, 16'd65535, 1'b1, 16'd0, 1'b1, 16'd0, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd65535, 1'b1, 16'd0, 1'b1, 16'd60000, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd0,     1'b1, 16'd0, 1'b1, 16'd1000,  1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd33000, 1'b1, 16'd0, 1'b1, 16'd30500, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'hAAAA, 1'b1, 16'h5555, 1'b0, 16'd0, 1'b0},
        // ceiling below idle: mapped value clamps to the ceiling, unsynced target does not
        '{ROW_WRITE, REG_DUTY_CEIL, 16'd0, CMD_TICK, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd65535, 1'b1, 16'd0, 1'b1, 16'd0,    1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd65535, 1'b0, 16'd0, 1'b1, 16'd1000, 1'b0},
        '{ROW_WRITE, REG_IDLE_DUTY, 16'd65535, CMD_TICK, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, REG_DUTY_CEIL, 16'd65535, CMD_TICK, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd40000, 1'b1, 16'd0, 1'b1, 16'd65535, 1'b0},
        // zero slew freezes both directions
        '{ROW_WRITE, REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, REG_SLEW_UP,   16'd0, CMD_TICK, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, REG_SLEW_DOWN, 16'd0, CMD_TICK, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK,  16'd0,     1'b0, 16'd0,   1'b1, 16'd65535, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_ENTER, 16'd0,     1'b0, 16'd100, 1'b1, 16'd100,   1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK,  16'd65535, 1'b1, 16'd0,   1'b1, 16'd100,   1'b0},
        // longest settle hold
        '{ROW_WRITE, REG_SETTLE_TICKS, 16'd65535, CMD_TICK, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_ENTER, 16'd0, 1'b1, 16'h5555, 1'b1, 16'h5555, 1'b1},
        '{ROW_BEAT,  REG_IDLE_DUTY, 16'd0, CMD_TICK, 16'd9000, 1'b1, 16'd0, 1'b1, 16'h5555, 1'b1}
    };

    // throttle map: dead zone gives idle, above it a line from idle to the ceiling
    function automatic logic [DUTY_W-1:0] throttle_goal(input logic [DUTY_W-1:0] pot);
        logic [DUTY_W-1:0]   span;
        logic [DUTY_W-1:0]   adj;
        logic [3*DUTY_W-1:0] mapped;
        if (pot < DEAD_ZONE)
            return reg_shadow.idle_duty;
        span = (reg_shadow.duty_ceil >= reg_shadow.idle_duty) ?
               reg_shadow.duty_ceil - reg_shadow.idle_duty : '0;
        adj = (pot > POT_TOP) ? POT_SPAN : pot - DEAD_ZONE;
        mapped = (3*DUTY_W)'(reg_shadow.idle_duty) +
                 ((3*DUTY_W)'(adj) * (3*DUTY_W)'(span)) / (3*DUTY_W)'(POT_SPAN);
        if (mapped > (3*DUTY_W)'(reg_shadow.duty_ceil))
            mapped = (3*DUTY_W)'(reg_shadow.duty_ceil);
        return mapped[DUTY_W-1:0];
    endfunction

    // advance the held duty by one beat and return the duty beat it causes
    function automatic t_out_item step_held_duty(input t_in_item beat);
        logic [DUTY_W-1:0] goal;
        t_out_item         res;
        if (beat.command == CMD_ENTER) begin
            duty_now  = beat.seed_duty;
            hold_left = reg_shadow.settle_ticks;
        end else if (hold_left != '0) begin
            hold_left = hold_left - 1'b1;
        end else begin
            goal = beat.zc_synced ? throttle_goal(beat.pot_raw) : reg_shadow.idle_duty;
            if (goal > duty_now) begin
                duty_now += (goal - duty_now > reg_shadow.slew_up) ?
                            reg_shadow.slew_up : goal - duty_now;
            end else if (duty_now > goal) begin
                duty_now -= (duty_now - goal > reg_shadow.slew_down) ?
                            reg_shadow.slew_down : duty_now - goal;
            end
        end
        res.duty     = duty_now;
        res.settling = (hold_left != '0);
        return res;
    endfunction

    // random beat: mostly synced ticks, pot aimed often at the map edges
    function automatic t_in_item random_beat(input int enter_pct);
        t_in_item beat;
        beat.command   = ($urandom_range(99) < enter_pct) ? CMD_ENTER : CMD_TICK;
        beat.zc_synced = ($urandom_range(9) != 0);
        beat.seed_duty = DUTY_W'($urandom);
        case ($urandom_range(5))
            0: beat.pot_raw = DEAD_ZONE - 16'd8 + DUTY_W'($urandom_range(16));
            1: beat.pot_raw = POT_TOP - 16'd8 + DUTY_W'($urandom_range(16));
            2: beat.pot_raw = $urandom_range(1) ? '1 : '0;
            default: beat.pot_raw = DUTY_W'($urandom);
        endcase
        return beat;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, what);
    endtask

    // offer one beat, with random gaps ahead of it, and log its expected result
    task automatic send_beat(input t_in_item beat, input bit typed, input t_out_item typed_res);
        t_out_item model_res;
        while ($urandom_range(99) < send_gap_pct) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid     = 1'b1;
        in_ch.command   = beat.command;
        in_ch.pot_raw   = beat.pot_raw;
        in_ch.zc_synced = beat.zc_synced;
        in_ch.seed_duty = beat.seed_duty;
        do @(posedge i_clk); while (!in_ch.ready);
        model_res = step_held_duty(beat);
        duty_expect_q.push_back(typed ? typed_res : model_res);
    endtask

    // stop offering and let every owed duty beat come back
    task automatic drain_block();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (duty_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [DUTY_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_IDLE_DUTY:    reg_shadow.idle_duty    = val;
            REG_DUTY_CEIL:    reg_shadow.duty_ceil    = val;
            REG_SLEW_UP:      reg_shadow.slew_up      = val;
            REG_SLEW_DOWN:    reg_shadow.slew_down    = val;
            REG_SETTLE_TICKS: reg_shadow.settle_ticks = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // register settings per random phase, extremes in phases 0 and 2
    task automatic program_phase(input int phase);
        logic [DUTY_W-1:0] idle_v;
        logic [DUTY_W-1:0] max_v;
        logic [DUTY_W-1:0] up_v;
        logic [DUTY_W-1:0] down_v;
        logic [DUTY_W-1:0] settle_v;
        case (phase)
            0: begin
                idle_v = '0;
                max_v  = '1;
                up_v   = DUTY_W'($urandom_range(600, 1));
                down_v = DUTY_W'($urandom_range(600, 1));
                settle_v = 16'd3;
            end
            1: begin
                idle_v = DUTY_W'($urandom);
                max_v  = DUTY_W'($urandom);
                up_v   = DUTY_W'($urandom);
                down_v = DUTY_W'($urandom);
                settle_v = DUTY_W'($urandom_range(12));
            end
            2: begin
                idle_v = '1;
                max_v  = '0;
                up_v   = '1;
                down_v = '1;
                settle_v = '0;
            end
            default: begin
                idle_v = DUTY_W'($urandom_range(4000));
                max_v  = DUTY_W'($urandom_range(65535, 30000));
                up_v   = $urandom_range(3) == 0 ? '0 : DUTY_W'($urandom_range(3000, 1));
                down_v = $urandom_range(3) == 0 ? '0 : DUTY_W'($urandom_range(3000, 1));
                settle_v = DUTY_W'($urandom_range(8));
            end
        endcase
        write_reg(REG_IDLE_DUTY, idle_v);
        write_reg(REG_DUTY_CEIL, max_v);
        write_reg(REG_SLEW_UP, up_v);
        write_reg(REG_SLEW_DOWN, down_v);
        write_reg(REG_SETTLE_TICKS, settle_v);
    endtask

    // result side: random stalls, plus one long hold on request
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare every accepted duty beat with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (duty_expect_q.size() == 0) begin
                note_failure($sformatf("unexpected beat duty=%0d settling=%0d",
                                       res_ch.duty, res_ch.settling));
            end else begin
                want = duty_expect_q.pop_front();
                if (res_ch.duty !== want.duty)
                    note_failure($sformatf("duty mismatch: expected %0d, got %0d",
                                           want.duty, res_ch.duty));
                if (res_ch.settling !== want.settling)
                    note_failure($sformatf("settling mismatch: expected %0d, got %0d",
                                           want.settling, res_ch.settling));
            end
        end
    end

    // watchdog on cycles without any handshake on any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // stimulus: reset, directed plan, then random phases
    initial begin
        t_in_item  beat;
        t_out_item typed_res;
        t_plan_row row;
        int        phase_gap  [PHASES];
        int        phase_stall[PHASES];

        phase_gap   = '{0, 70, 0, 22, 0};
        phase_stall = '{0, 0, 70, 22, 0};

        // every input known from time zero
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_TICK;
        in_ch.pot_raw   = '0;
        in_ch.zc_synced = 1'b0;
        in_ch.seed_duty = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_IDLE_DUTY;
        cfg_ch.data     = '0;

        // predictor starts from the reset defaults
        reg_shadow.idle_duty    = RST_IDLE_DUTY;
        reg_shadow.duty_ceil    = RST_DUTY_CEIL;
        reg_shadow.slew_up      = RST_SLEW_UP;
        reg_shadow.slew_down    = RST_SLEW_DOWN;
        reg_shadow.settle_ticks = RST_SETTLE_TICKS;
        duty_now  = '0;
        hold_left = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed plan, no idling; writes only once the block is empty
        foreach (dir_plan[i]) begin
            row = dir_plan[i];
            if (row.kind == ROW_WRITE) begin
                drain_block();
                write_reg(row.reg_idx, row.wdata);
            end else begin
                beat.command   = row.command;
                beat.pot_raw   = row.pot_raw;
                beat.zc_synced = row.zc_synced;
                beat.seed_duty = row.seed_duty;
                typed_res.duty     = row.want_duty;
                typed_res.settling = row.want_settling;
                send_beat(beat, row.typed, typed_res);
            end
        end

        // random phases: each opens with an enter beat, then mostly ticks
        for (int p = 0; p < PHASES; p++) begin
            drain_block();
            program_phase(p);
            send_gap_pct   = phase_gap[p];
            recv_stall_pct = phase_stall[p];
            beat = random_beat(0);
            beat.command = CMD_ENTER;
            send_beat(beat, 1'b0, typed_res);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                // back-pressure: result side holds off while beats keep coming
                if (p == 0 && k == 40)
                    hold_req = 1'b1;
                send_beat(random_beat(4), 1'b0, typed_res);
            end
        end

        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && duty_expect_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
